[hdl/pwlsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlsl_pkg
// Shared types, codes and widths of the piecewise-linear sensor linearizer.
// ----------------------------------------------------------------------------
package pwlsl_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int CMD_W    = 1;
  localparam int IDX_W    = 5;
  localparam int VAL_W    = 10;
  localparam int SAMPLE_W = 10;
  localparam int DIST_W   = 12;
  localparam int STATUS_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int TSIZE_W = 6;
  localparam int START_W = 10;
  localparam int STEP_W  = 8;
  localparam int MINR_W  = 10;

  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_QUO_W = 12;

  localparam logic [CMD_W-1:0] CMD_MEASURE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSEG  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FLAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISTANCE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE      = 2'd3;

  localparam logic [TSIZE_W-1:0] TSIZE_RST = 6'd14;
  localparam logic [START_W-1:0] START_RST = 10'd20;
  localparam logic [STEP_W-1:0]  STEP_RST  = 8'd10;
  localparam logic [MINR_W-1:0]  MINR_RST  = 10'd20;

  localparam logic [DIST_W-1:0] DIST_MAX = 12'd4095;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/pwlsl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlsl_item_if / pwlsl_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pwlsl_item_if;
  import pwlsl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [IDX_W-1:0]    entry_index;
  logic [VAL_W-1:0]    entry_value;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, cmd, entry_index, entry_value, sample, input ready);
  modport sink   (input valid, cmd, entry_index, entry_value, sample, output ready);
endinterface

interface pwlsl_result_if;
  import pwlsl_pkg::*;
  logic                valid;
  logic                ready;
  logic [DIST_W-1:0]   distance;
  logic [STATUS_W-1:0] status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

[hdl/pwlsl_table_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlsl_table_mem
// Calibration table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pwlsl_table_mem #(
  parameter int DEPTH = pwlsl_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(pwlsl_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [pwlsl_pkg::VAL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [pwlsl_pkg::VAL_W-1:0] rdata
);
  import pwlsl_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/pwlsl_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlsl_divider
// Restoring divider, one quotient bit per cycle; quotient must fit 12 bits.
// ----------------------------------------------------------------------------
module pwlsl_divider (
  input  logic                clk,
  input  logic                rst,
  input  pwlsl_pkg::div_req_t req,
  output pwlsl_pkg::div_rsp_t rsp
);
  import pwlsl_pkg::*;

  localparam int CNT_W = $clog2(DIV_QUO_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_QUO_W-1:0] sh;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem, sh[DIV_QUO_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[DIV_NUM_W-1 -: DIV_DEN_W];
      sh  <= req.num[DIV_QUO_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      sh  <= {sh[DIV_QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = sh;

endmodule

[hdl/piecewise_linear_sensor_linearizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_sensor_linearizer
// IR sensor ADC sample to distance in mm by piecewise-linear table lookup.
// ----------------------------------------------------------------------------
// A load item writes one calibration entry and gives no result. A measure
// item walks the table from the top of the active range downward, one entry
// per cycle through the table memory's read port. A hit then passes through
// the multiply, add and range-check states; a flat segment ends after the
// multiply. Unless the result is negative or saturates, the bit-serial divider
// then forms the quotient, and the result is placed in the output register.
// Items are handled one at a time; the next item is taken while a finished
// result still waits in the output register.
// The table has no reset and needs no clearing pass; entries read before
// being written return whatever the memory holds.
// ----------------------------------------------------------------------------
module piecewise_linear_sensor_linearizer #(
  parameter int TABLE_DEPTH = pwlsl_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = pwlsl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  pwlsl_item_if.sink                       item_in,
  pwlsl_result_if.source                   result_out,
  input  logic                             cfg_we,
  input  logic [pwlsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwlsl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwlsl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = AW + 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_MUL1   = 3'd2;
  localparam logic [2:0] ST_MUL2   = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;
  localparam logic [2:0] ST_CHK    = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state;

  logic [TSIZE_W-1:0] table_size;
  logic [START_W-1:0] start_distance;
  logic [STEP_W-1:0]  step_distance;
  logic [MINR_W-1:0]  fallback_distance;

  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_last;
  logic [AW-1:0] last_idx;

  logic          in_acc;
  logic [6:0]    idx_ext;
  logic          load_ok;
  logic          mem_we;
  logic [VAL_W-1:0] rdata;

  logic [AW-1:0]    ptr;
  logic [AW-1:0]    cmp_idx;
  logic             cmp_vld;
  logic [VAL_W-1:0] x_q;
  logic [VAL_W-1:0] prev_q;
  logic [VAL_W-1:0] x1_q;
  logic [AW-1:0]    seg_q;

  logic signed [15:0] y1_q;
  logic signed [10:0] den_q;
  logic signed [10:0] dx;
  logic signed [19:0] p2_q;
  logic signed [26:0] p1_q;
  logic signed [27:0] sum_s;
  logic signed [27:0] num_next;
  logic        [27:0] num_q;
  logic signed [10:0] den_neg;
  logic [DIV_DEN_W-1:0] dabs_q;
  logic        num_neg;
  logic        num_sat;
  logic [15:0] seg_step;

  logic [DIST_W-1:0]   res_dist;
  logic [STATUS_W-1:0] res_stat;
  logic                out_valid;
  logic [DIST_W-1:0]   out_dist;
  logic [STATUS_W-1:0] out_stat;
  logic                out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    if (table_size < TSIZE_W'(2)) begin
      n_eff = NW'(2);
    end else if (7'(table_size) > 7'(TABLE_DEPTH)) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = NW'(table_size);
    end
  end
  assign n_last   = n_eff - NW'(1);
  assign last_idx = n_last[AW-1:0];

  assign item_in.ready = (state == ST_IDLE);
  assign in_acc  = item_in.valid && item_in.ready;
  assign idx_ext = 7'(item_in.entry_index);
  assign load_ok = idx_ext < 7'(TABLE_DEPTH);
  assign mem_we  = in_acc && (item_in.cmd == CMD_LOAD) && load_ok;

  pwlsl_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (item_in.entry_value),
    .re    (state == ST_SEARCH),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign dx       = $signed({1'b0, x_q}) - $signed({1'b0, x1_q});
  assign seg_step = 16'(seg_q) * 16'(step_distance);
  assign sum_s    = 28'(p1_q) + 28'(p2_q);
  assign num_next = den_q[10] ? -sum_s : sum_s;
  assign den_neg  = -den_q;
  assign num_neg  = num_q[27];
  assign num_sat  = num_q >= 28'({dabs_q, 12'd0});

  assign div_req.start = (state == ST_CHK) && !num_neg && !num_sat;
  assign div_req.num   = num_q[DIV_NUM_W-1:0];
  assign div_req.den   = dabs_q;

  pwlsl_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size        <= TSIZE_RST;
      start_distance    <= START_RST;
      step_distance     <= STEP_RST;
      fallback_distance <= MINR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_SIZE:     table_size        <= cfg_data[TSIZE_W-1:0];
        CFG_START_DISTANCE: start_distance    <= cfg_data[START_W-1:0];
        CFG_STEP_DISTANCE:  step_distance     <= cfg_data[STEP_W-1:0];
        CFG_MIN_RANGE:      fallback_distance <= cfg_data[MINR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cmp_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cmp_vld <= 1'b0;
          if (in_acc && (item_in.cmd == CMD_MEASURE)) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          cmp_vld <= 1'b1;
          if (cmp_vld && (cmp_idx != last_idx)) begin
            if (x_q < rdata) begin
              state <= ST_MUL1;
            end else if (cmp_idx == '0) begin
              state <= ST_DONE;
            end
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= (den_q == '0) ? ST_DONE : ST_SUM;
        ST_SUM:  state <= ST_CHK;
        ST_CHK:  state <= (num_neg || num_sat) ? ST_DONE : ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x_q <= item_in.sample & SAMPLE_MASK;
        ptr <= last_idx;
      end
      ST_SEARCH: begin
        cmp_idx <= ptr;
        if (ptr != '0) begin
          ptr <= ptr - AW'(1);
        end
        if (cmp_vld) begin
          if (cmp_idx == last_idx) begin
            prev_q <= rdata;
          end else if (x_q < rdata) begin
            x1_q  <= rdata;
            seg_q <= cmp_idx;
          end else if (cmp_idx == '0) begin
            res_dist <= DIST_W'(fallback_distance);
            res_stat <= STATUS_NOSEG;
          end else begin
            prev_q <= rdata;
          end
        end
      end
      ST_MUL1: begin
        y1_q  <= $signed(16'(start_distance) + seg_step);
        den_q <= $signed({1'b0, prev_q}) - $signed({1'b0, x1_q});
        p2_q  <= dx * $signed({1'b0, step_distance});
      end
      ST_MUL2: begin
        p1_q <= y1_q * den_q;
        if (den_q == '0) begin
          res_dist <= (y1_q > 16'sd4095) ? DIST_MAX : y1_q[DIST_W-1:0];
          res_stat <= STATUS_FLAT;
        end
      end
      ST_SUM: begin
        num_q  <= num_next;
        dabs_q <= den_q[10] ? den_neg[DIV_DEN_W-1:0] : den_q[DIV_DEN_W-1:0];
      end
      ST_CHK: begin
        res_stat <= STATUS_INTERP;
        res_dist <= num_neg ? '0 : DIST_MAX;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_dist <= div_rsp.quot;
          res_stat <= STATUS_INTERP;
        end
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_dist <= res_dist;
      out_stat <= res_stat;
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.distance = out_dist;
  assign result_out.status   = out_stat;

endmodule

[hdl/pwlsl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlsl_checker
// Port-level checks of the linearizer, bound to the top level.
// ----------------------------------------------------------------------------
module pwlsl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [pwlsl_pkg::CMD_W-1:0]      in_cmd,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pwlsl_pkg::DIST_W-1:0]     out_distance,
  input logic [pwlsl_pkg::STATUS_W-1:0]   out_status
);
  import pwlsl_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == STATUS_INTERP || out_status == STATUS_NOSEG ||
                   out_status == STATUS_FLAT))
    else $error("result status outside defined codes");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_status))
    else $error("stalled result item changed");

  a_measure_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_cmd == CMD_MEASURE) |=> !in_ready)
    else $error("input taken while a measure item is in progress");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_cmd == CMD_LOAD) |=> in_ready)
    else $error("load item stalled the input");

endmodule

bind piecewise_linear_sensor_linearizer pwlsl_checker u_pwlsl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .in_cmd       (item_in.cmd),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .out_distance (result_out.distance),
  .out_status   (result_out.status)
);

[tb/pwlsl_distance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlsl_distance_checker
// Watches the item, result and register ports of the sensor linearizer,
// keeps its own copy of the calibration table and registers, predicts the
// distance reading of each measure item and compares readings in order.
// ----------------------------------------------------------------------------
module pwlsl_distance_checker (
  input  logic                             clk,
  input  logic                             rst,
  pwlsl_item_if                            items,
  pwlsl_result_if                          readings,
  input  logic                             cfg_we,
  input  logic [pwlsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwlsl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               outstanding,
  output int                               interp_seen,
  output int                               noseg_seen,
  output int                               flat_seen
);
  import pwlsl_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [STATUS_W-1:0] status;
  } reading_t;

  logic [TSIZE_W-1:0] size_reg;
  logic [START_W-1:0] start_reg;
  logic [STEP_W-1:0]  step_reg;
  logic [MINR_W-1:0]  minr_reg;
  logic [VAL_W-1:0]   cal_copy [TABLE_DEPTH_DEF];

  reading_t expected_readings [$];

  initial begin
    fail_count  = 0;
    interp_seen = 0;
    noseg_seen  = 0;
    flat_seen   = 0;
  end

  function automatic logic [DIST_W-1:0] saturate(input longint v);
    if (v < 0) return '0;
    if (v > longint'(DIST_MAX)) return DIST_MAX;
    return v[DIST_W-1:0];
  endfunction

  function automatic reading_t predict_distance(input logic [SAMPLE_W-1:0] smp);
    reading_t r;
    int       span;
    bit       found;
    longint   x, x1, x2, y1, den, num;
    span = int'(size_reg);
    if (span < 2) span = 2;
    if (span > TABLE_DEPTH_DEF) span = TABLE_DEPTH_DEF;
    x = longint'(smp);
    found = 1'b0;
    r.distance = DIST_W'(minr_reg);
    r.status   = STATUS_NOSEG;
    for (int i = span - 2; i >= 0 && !found; i--) begin
      if (x < longint'(cal_copy[i])) begin
        x1  = longint'(cal_copy[i]);
        x2  = longint'(cal_copy[i+1]);
        y1  = longint'(start_reg) + longint'(i) * longint'(step_reg);
        den = x2 - x1;
        if (den == 0) begin
          r.distance = saturate(y1);
          r.status   = STATUS_FLAT;
        end else begin
          num        = y1 * den + (x - x1) * longint'(step_reg);
          r.distance = saturate(num / den);
          r.status   = STATUS_INTERP;
        end
        found = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      size_reg  = TSIZE_RST;
      start_reg = START_RST;
      step_reg  = STEP_RST;
      minr_reg  = MINR_RST;
      expected_readings.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_SIZE:     size_reg  = cfg_data[TSIZE_W-1:0];
          CFG_START_DISTANCE: start_reg = cfg_data[START_W-1:0];
          CFG_STEP_DISTANCE:  step_reg  = cfg_data[STEP_W-1:0];
          CFG_MIN_RANGE:      minr_reg  = cfg_data[MINR_W-1:0];
          default: ;
        endcase
      end
      if (readings.valid && readings.ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading with no measure item pending: distance %0d status %0d",
                 readings.distance, readings.status);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (readings.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, readings.distance);
            fail_count++;
          end
          if (readings.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, readings.status);
            fail_count++;
          end
          case (want.status)
            STATUS_INTERP: interp_seen++;
            STATUS_NOSEG:  noseg_seen++;
            default:       flat_seen++;
          endcase
        end
      end
      if (items.valid && items.ready) begin
        if (items.cmd == CMD_LOAD) begin
          cal_copy[items.entry_index] = items.entry_value;
        end else begin
          expected_readings.push_back(predict_distance(items.sample));
        end
      end
      outstanding <= expected_readings.size();
    end
  end

endmodule

[tb/tb_piecewise_linear_sensor_linearizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_sensor_linearizer
// Drives table loads, register settings and measure samples into the sensor
// linearizer under several idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_sensor_linearizer;
  import pwlsl_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 43;

  typedef enum int {
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_STAIRS,
    SHAPE_SCATTER
  } shape_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          fail_count, outstanding, interp_seen, noseg_seen, flat_seen;
  int unsigned send_pct, recv_pct;
  int          cur_size;
  int          items_sent;
  int          quiet_cycles;
  logic [VAL_W-1:0] shadow_cal [TABLE_DEPTH_DEF];

  pwlsl_item_if   item_bus ();
  pwlsl_result_if result_bus ();

  piecewise_linear_sensor_linearizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_bus),
    .result_out (result_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pwlsl_distance_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .items       (item_bus),
    .readings    (result_bus),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .interp_seen (interp_seen),
    .noseg_seen  (noseg_seen),
    .flat_seen   (flat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_bus.ready <= !rst && ($urandom_range(99) >= recv_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item or reading accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
                           input logic [VAL_W-1:0] v, input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.cmd         <= c;
    item_bus.entry_index <= ix;
    item_bus.entry_value <= v;
    item_bus.sample      <= s;
    do @(posedge clk); while (!item_bus.ready);
    if (c == CMD_LOAD) shadow_cal[ix] = v;
    items_sent++;
  endtask

  task automatic load(input int ix, input int v);
    send_item(CMD_LOAD, IDX_W'(ix), VAL_W'(v), SAMPLE_W'($urandom));
  endtask

  task automatic measure(input int s);
    send_item(CMD_MEASURE, IDX_W'($urandom), VAL_W'($urandom), SAMPLE_W'(s));
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input int d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_DATA_W'(d);
    @(posedge clk);
  endtask

  task automatic apply_config(input int tsize, input int start, input int step, input int minr);
    write_reg(CFG_TABLE_SIZE, tsize);
    write_reg(CFG_START_DISTANCE, start);
    write_reg(CFG_STEP_DISTANCE, step);
    write_reg(CFG_MIN_RANGE, minr);
    cfg_we <= 1'b0;
    cur_size = tsize < 2 ? 2 : (tsize > TABLE_DEPTH_DEF ? TABLE_DEPTH_DEF : tsize);
  endtask

  task automatic set_idle(input idle_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 67; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 67; end
      default:   begin send_pct = 31; recv_pct = 31; end
    endcase
  endtask

  task automatic fill_table(input shape_t shape);
    int level;
    level = 0;
    for (int k = 0; k < TABLE_DEPTH_DEF; k++) begin
      case (shape)
        SHAPE_FALLING: level = (k == 0) ? int'($urandom_range(1023, 900))
                                        : level - int'($urandom_range(40, 1));
        SHAPE_RISING:  level = (k == 0) ? int'($urandom_range(100, 0))
                                        : level + int'($urandom_range(40, 1));
        SHAPE_STAIRS:  level = (k == 0) ? int'($urandom_range(1023, 800))
                                        : level - int'($urandom_range(2, 0) * $urandom_range(30, 0));
        default:       level = int'($urandom_range(1023, 0));
      endcase
      if (level < 0) level = 0;
      if (level > 1023) level = 1023;
      load(k, level);
    end
  endtask

  task automatic random_item();
    int pick, k, s;
    pick = int'($urandom_range(99));
    k    = int'($urandom_range(cur_size - 1, 0));
    if (pick < 10) begin
      load(int'($urandom), int'($urandom));
    end else begin
      if (pick < 50)      s = int'(shadow_cal[k]) + int'($urandom_range(6)) - 3;
      else if (pick < 65) s = int'(shadow_cal[k]);
      else if (pick < 85) s = int'($urandom_range(1023));
      else if (pick < 92) s = 0;
      else                s = 1023;
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      measure(s);
    end
  endtask

  task automatic phase_config(input int p);
    case (p)
      1: apply_config(32, 0, 1, 0);
      2: apply_config(32, 1023, 255, 1023);
      3: apply_config(0, 512, 0, 341);
      4: apply_config(63, 682, 170, 682);
      5: apply_config(1, 341, 85, 1);
      6: apply_config(33, 100, 200, 1000);
      default: apply_config(($urandom_range(9) < 8) ? int'($urandom_range(32, 2))
                                                    : int'($urandom_range(63)),
                            int'($urandom_range(1023)), int'($urandom_range(255)),
                            int'($urandom_range(1023)));
    endcase
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    item_bus.valid       <= 1'b0;
    item_bus.cmd         <= CMD_MEASURE;
    item_bus.entry_index <= '0;
    item_bus.entry_value <= '0;
    item_bus.sample      <= '0;
    items_sent = 0;
    cur_size   = int'(TSIZE_RST);
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < TABLE_DEPTH_DEF; k++) load(k, 1000 - 30 * k);
    measure(0);
    measure(1023);
    measure(1000);
    measure(999);
    measure(985);
    measure(640);
    measure(639);
    load(13, 640);
    measure(600);
    measure(700);
    load(13, 900);
    measure(0);
    measure(630);
    load(13, 610);
    load(31, 1023);
    load(30, 0);
    measure(512);
    measure(69);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        phase_config(p);
      end
      set_idle(idle_t'(p % 4));
      fill_table(shape_t'((p / 4 + p) % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    drain();
    $display("Sent %0d items over %0d phases of table shapes, settings and idle patterns",
             items_sent, PHASES);
    $display("Readings checked: %0d interpolated, %0d no segment, %0d flat",
             interp_seen, noseg_seen, flat_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
